// ===== design/ttr_pkg.sv =====
// Shared widths, types and register codes for the triangle tile rasterizer.
// Used by the channel interfaces and the top level; depends on nothing.
package ttr_pkg;

    localparam int COORD_W = 20;   // vertex coordinate, 1/16 pixel
    localparam int RGB_W   = 24;   // packed 8:8:8 color
    localparam int CH_W    = 8;    // one color channel
    localparam int TILE_W  = 9;    // tile column or row index
    localparam int POS_W   = 12;   // pixel coordinate
    localparam int SCR_W   = 13;   // screen size register
    localparam int DIFF_W  = 22;   // coordinate difference
    localparam int WF_W    = 45;   // edge function and area
    localparam int ACC_W   = 53;   // multiply-accumulate and division width

    localparam int CFG_IDX_W = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [RGB_W-1:0]   t_rgb;
    typedef logic        [CH_W-1:0]    t_chan;
    typedef logic        [TILE_W-1:0]  t_tile;
    typedef logic        [POS_W-1:0]   t_pos;
    typedef logic        [SCR_W-1:0]   t_scr;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [WF_W-1:0]    t_wf;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 1'b1;

    localparam t_scr SCREEN_WIDTH_RST  = 13'd640;
    localparam t_scr SCREEN_HEIGHT_RST = 13'd480;
    localparam t_scr MAX_SCREEN        = 13'd4096;

endpackage

// ===== design/ttr_tri_if.sv =====
// Input channel of the rasterizer: one triangle and one tile per transfer.
// Depends on ttr_pkg for field types.
interface ttr_tri_if;
    logic           valid;
    logic           ready;
    ttr_pkg::t_coord vx1;
    ttr_pkg::t_coord vy1;
    ttr_pkg::t_coord vx2;
    ttr_pkg::t_coord vy2;
    ttr_pkg::t_coord vx3;
    ttr_pkg::t_coord vy3;
    ttr_pkg::t_rgb   rgb1;
    ttr_pkg::t_rgb   rgb2;
    ttr_pkg::t_rgb   rgb3;
    ttr_pkg::t_tile  tile_col;
    ttr_pkg::t_tile  tile_row;

    modport source (output valid, vx1, vy1, vx2, vy2, vx3, vy3, rgb1, rgb2, rgb3,
                    tile_col, tile_row, input ready);
    modport sink   (input valid, vx1, vy1, vx2, vy2, vx3, vy3, rgb1, rgb2, rgb3,
                    tile_col, tile_row, output ready);
endinterface

// ===== design/ttr_pix_if.sv =====
// Output channel of the rasterizer: one shaded pixel per transfer.
// Depends on ttr_pkg for field types.
interface ttr_pix_if;
    logic          valid;
    logic          ready;
    ttr_pkg::t_pos pixel_x;
    ttr_pkg::t_pos pixel_y;
    ttr_pkg::t_rgb pixel_rgb;
    logic          last_of_tile;

    modport source (output valid, pixel_x, pixel_y, pixel_rgb, last_of_tile, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_rgb, last_of_tile, output ready);
endinterface

// ===== design/triangle_tile_rasterizer.sv =====
// Triangle tile rasterizer with Gouraud shading: edge functions, coverage and color division.
// Depends on ttr_pkg, ttr_tri_if and ttr_pix_if.

// One triangle transfer carries three vertices (signed, 1/16 pixel) with colors and the
// index of one TILE_SIDE x TILE_SIDE tile. The block takes one triangle at a time: after
// the transfer it computes the clamped bounding box, then the area, and walks the tile's
// part of the box in row-major order. All products go through one registered
// multiply-accumulate unit: an uncovered pixel takes the edge functions, each a difference
// of products, plus a step, and a covered pixel adds the color products and a restoring
// division per channel. An empty or back-facing triangle ends after the area. Each covered
// pixel leaves through an output register; the newest one is held back until the next
// is found so that the final pixel can carry last_of_tile. Input ready is high only
// between triangles. Screen size registers may be written only while the block is idle.
module triangle_tile_rasterizer #(
    parameter int TILE_SIDE = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  ttr_pkg::t_cfg_idx       i_cfg_idx,
    input  ttr_pkg::t_scr           i_cfg_data,
    ttr_tri_if.sink                 i_tri,
    ttr_pix_if.source               o_pix
);

    localparam int TL_W  = ttr_pkg::TILE_W + $clog2(TILE_SIDE) + 1;
    localparam int CMP_W = 14;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_PUSH  = 8'b0010_0000,
        S_STEP  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    // Micro-operations of the multiply-accumulate unit.
    typedef enum logic [3:0] {
        OP_AREA_A, OP_AREA_B, OP_W1A, OP_W1B, OP_W2A, OP_W2B, OP_W3A, OP_W3B,
        OP_C1, OP_C2, OP_C3
    } t_op;

    t_state r_state;
    t_op    r_op;

    ttr_pkg::t_scr   r_sw, r_sh;
    ttr_pkg::t_coord r_vx1, r_vy1, r_vx2, r_vy2, r_vx3, r_vy3;
    ttr_pkg::t_rgb   r_c1, r_c2, r_c3;
    ttr_pkg::t_tile  r_tc, r_tr;

    ttr_pkg::t_pos   r_lx0, r_lx1, r_ly0, r_ly1, r_x, r_y;
    logic            r_empty;

    ttr_pkg::t_acc   r_prod, r_acc, r_rem, r_dsr;
    ttr_pkg::t_wf    r_area, r_w1, r_w2, r_w3;
    logic [1:0]      r_ch;
    logic [2:0]      r_dcnt;
    ttr_pkg::t_chan  r_q;
    ttr_pkg::t_rgb   r_rgb;

    logic            r_pend_v;
    ttr_pkg::t_pos   r_pend_x, r_pend_y;
    ttr_pkg::t_rgb   r_pend_rgb;

    logic            r_ovalid;
    ttr_pkg::t_pos   r_ox, r_oy;
    ttr_pkg::t_rgb   r_orgb;
    logic            r_olast;

    // ---------------- helpers ----------------
    function automatic ttr_pkg::t_diff diff(input ttr_pkg::t_diff a, input ttr_pkg::t_coord b);
        return a - ttr_pkg::t_diff'(b);
    endfunction

    function automatic ttr_pkg::t_coord min3(input ttr_pkg::t_coord a,
                                             input ttr_pkg::t_coord b,
                                             input ttr_pkg::t_coord c);
        ttr_pkg::t_coord m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic ttr_pkg::t_coord max3(input ttr_pkg::t_coord a,
                                             input ttr_pkg::t_coord b,
                                             input ttr_pkg::t_coord c);
        ttr_pkg::t_coord m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Floor to whole pixels and clamp into [0, lim-1]; lim is at least 1 when used.
    function automatic ttr_pkg::t_pos clamp_px(input ttr_pkg::t_coord v,
                                               input ttr_pkg::t_scr lim);
        ttr_pkg::t_coord   f;
        logic signed [20:0] fe;
        logic signed [20:0] le;
        ttr_pkg::t_scr     lm1;
        f   = v >>> 4;
        fe  = 21'(f);
        le  = $signed({8'b0, lim});
        lm1 = lim - 13'd1;
        if (fe < 0) begin
            return '0;
        end else if (fe >= le) begin
            return lm1[ttr_pkg::POS_W-1:0];
        end else begin
            return fe[ttr_pkg::POS_W-1:0];
        end
    endfunction

    function automatic ttr_pkg::t_chan chan(input ttr_pkg::t_rgb c, input logic [1:0] ch);
        ttr_pkg::t_chan b;
        unique case (ch)
            2'd0:    b = c[23:16];
            2'd1:    b = c[15:8];
            default: b = c[7:0];
        endcase
        return b;
    endfunction

    // ---------------- box and tile window ----------------
    ttr_pkg::t_scr  sw_e, sh_e;
    ttr_pkg::t_pos  bx0, bx1, by0, by1;
    logic [TL_W-1:0] tx0, tx1, ty0, ty1;
    logic [CMP_W-1:0] wx0, wx1, wy0, wy1;
    logic            win_empty;

    always_comb begin
        sw_e = (r_sw > ttr_pkg::MAX_SCREEN) ? ttr_pkg::MAX_SCREEN : r_sw;
        sh_e = (r_sh > ttr_pkg::MAX_SCREEN) ? ttr_pkg::MAX_SCREEN : r_sh;
        bx0  = clamp_px(min3(r_vx1, r_vx2, r_vx3), sw_e);
        bx1  = clamp_px(max3(r_vx1, r_vx2, r_vx3), sw_e);
        by0  = clamp_px(min3(r_vy1, r_vy2, r_vy3), sh_e);
        by1  = clamp_px(max3(r_vy1, r_vy2, r_vy3), sh_e);
        tx0  = TL_W'(r_tc) * TL_W'(TILE_SIDE);
        tx1  = tx0 + TL_W'(TILE_SIDE - 1);
        ty0  = TL_W'(r_tr) * TL_W'(TILE_SIDE);
        ty1  = ty0 + TL_W'(TILE_SIDE - 1);
        wx0  = (CMP_W'(tx0) > CMP_W'(bx0)) ? CMP_W'(tx0) : CMP_W'(bx0);
        wx1  = (CMP_W'(tx1) < CMP_W'(bx1)) ? CMP_W'(tx1) : CMP_W'(bx1);
        wy0  = (CMP_W'(ty0) > CMP_W'(by0)) ? CMP_W'(ty0) : CMP_W'(by0);
        wy1  = (CMP_W'(ty1) < CMP_W'(by1)) ? CMP_W'(ty1) : CMP_W'(by1);
        win_empty = (sw_e == '0) || (sh_e == '0) || (wx0 > wx1) || (wy0 > wy1);
    end

    // ---------------- shared multiply-accumulate unit ----------------
    ttr_pkg::t_diff px, py;
    ttr_pkg::t_wf   mul_a;
    ttr_pkg::t_diff mul_b;
    logic signed [ttr_pkg::WF_W+ttr_pkg::DIFF_W-1:0] mul_p;
    ttr_pkg::t_acc  acc_new;

    always_comb begin
        px = ttr_pkg::t_diff'({6'b0, r_x, 4'b1000});
        py = ttr_pkg::t_diff'({6'b0, r_y, 4'b1000});
        unique case (r_op)
            OP_AREA_A: begin
                mul_a = ttr_pkg::t_wf'(diff(ttr_pkg::t_diff'(r_vx3), r_vx1));
                mul_b = diff(ttr_pkg::t_diff'(r_vy2), r_vy1);
            end
            OP_AREA_B: begin
                mul_a = ttr_pkg::t_wf'(diff(ttr_pkg::t_diff'(r_vy3), r_vy1));
                mul_b = diff(ttr_pkg::t_diff'(r_vx2), r_vx1);
            end
            OP_W1A: begin
                mul_a = ttr_pkg::t_wf'(diff(px, r_vx2));
                mul_b = diff(ttr_pkg::t_diff'(r_vy3), r_vy2);
            end
            OP_W1B: begin
                mul_a = ttr_pkg::t_wf'(diff(py, r_vy2));
                mul_b = diff(ttr_pkg::t_diff'(r_vx3), r_vx2);
            end
            OP_W2A: begin
                mul_a = ttr_pkg::t_wf'(diff(px, r_vx3));
                mul_b = diff(ttr_pkg::t_diff'(r_vy1), r_vy3);
            end
            OP_W2B: begin
                mul_a = ttr_pkg::t_wf'(diff(py, r_vy3));
                mul_b = diff(ttr_pkg::t_diff'(r_vx1), r_vx3);
            end
            OP_W3A: begin
                mul_a = ttr_pkg::t_wf'(diff(px, r_vx1));
                mul_b = diff(ttr_pkg::t_diff'(r_vy2), r_vy1);
            end
            OP_W3B: begin
                mul_a = ttr_pkg::t_wf'(diff(py, r_vy1));
                mul_b = diff(ttr_pkg::t_diff'(r_vx2), r_vx1);
            end
            OP_C1: begin
                mul_a = r_w1;
                mul_b = ttr_pkg::t_diff'({14'b0, chan(r_c1, r_ch)});
            end
            OP_C2: begin
                mul_a = r_w2;
                mul_b = ttr_pkg::t_diff'({14'b0, chan(r_c2, r_ch)});
            end
            OP_C3: begin
                mul_a = r_w3;
                mul_b = ttr_pkg::t_diff'({14'b0, chan(r_c3, r_ch)});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        unique case (r_op)
            OP_AREA_A, OP_W1A, OP_W2A, OP_W3A, OP_C1: acc_new = r_prod;
            OP_AREA_B, OP_W1B, OP_W2B, OP_W3B:       acc_new = r_acc - r_prod;
            default:                                 acc_new = r_acc + r_prod;
        endcase
    end

    // ---------------- divider step ----------------
    ttr_pkg::t_acc div_trial;
    logic          div_ge;
    assign div_trial = r_rem - r_dsr;
    assign div_ge    = !div_trial[ttr_pkg::ACC_W-1];

    logic out_free;
    assign out_free = !r_ovalid || o_pix.ready;

    // The output register takes the pending pixel in this cycle.
    logic out_load;
    assign out_load = r_pend_v && out_free && ((r_state == S_PUSH) || (r_state == S_FLUSH));

    logic at_end;
    assign at_end = (r_x == r_lx1) && (r_y == r_ly1);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_AREA_A;
            r_sw     <= ttr_pkg::SCREEN_WIDTH_RST;
            r_sh     <= ttr_pkg::SCREEN_HEIGHT_RST;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                priority if (i_cfg_idx == ttr_pkg::CFG_SCREEN_WIDTH) begin
                    r_sw <= i_cfg_data;
                end else if (i_cfg_idx == ttr_pkg::CFG_SCREEN_HEIGHT) begin
                    r_sh <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_pix.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_tri.valid) begin
                        r_vx1 <= i_tri.vx1;
                        r_vy1 <= i_tri.vy1;
                        r_vx2 <= i_tri.vx2;
                        r_vy2 <= i_tri.vy2;
                        r_vx3 <= i_tri.vx3;
                        r_vy3 <= i_tri.vy3;
                        r_c1  <= i_tri.rgb1;
                        r_c2  <= i_tri.rgb2;
                        r_c3  <= i_tri.rgb3;
                        r_tc  <= i_tri.tile_col;
                        r_tr  <= i_tri.tile_row;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_lx0   <= wx0[ttr_pkg::POS_W-1:0];
                    r_lx1   <= wx1[ttr_pkg::POS_W-1:0];
                    r_ly0   <= wy0[ttr_pkg::POS_W-1:0];
                    r_ly1   <= wy1[ttr_pkg::POS_W-1:0];
                    r_empty <= win_empty;
                    r_op    <= OP_AREA_A;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_p[ttr_pkg::ACC_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= acc_new;
                    unique case (r_op)
                        OP_AREA_B: begin
                            r_area <= acc_new[ttr_pkg::WF_W-1:0];
                            if (acc_new[ttr_pkg::ACC_W-1] || acc_new == '0 || r_empty) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_x     <= r_lx0;
                                r_y     <= r_ly0;
                                r_op    <= OP_W1A;
                                r_state <= S_MUL;
                            end
                        end
                        OP_W1B: begin
                            r_w1    <= acc_new[ttr_pkg::WF_W-1:0];
                            r_op    <= OP_W2A;
                            r_state <= S_MUL;
                        end
                        OP_W2B: begin
                            r_w2    <= acc_new[ttr_pkg::WF_W-1:0];
                            r_op    <= OP_W3A;
                            r_state <= S_MUL;
                        end
                        OP_W3B: begin
                            r_w3 <= acc_new[ttr_pkg::WF_W-1:0];
                            // Covered only when every edge function is non-negative.
                            if (r_w1[ttr_pkg::WF_W-1] || r_w2[ttr_pkg::WF_W-1] ||
                                acc_new[ttr_pkg::ACC_W-1]) begin
                                r_state <= S_STEP;
                            end else begin
                                r_ch    <= 2'd0;
                                r_op    <= OP_C1;
                                r_state <= S_MUL;
                            end
                        end
                        OP_C3: begin
                            r_rem   <= acc_new;
                            r_dsr   <= ttr_pkg::t_acc'({1'b0, r_area, 7'b0});
                            r_dcnt  <= 3'd0;
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= S_MUL;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_trial;
                    end
                    r_q    <= {r_q[ttr_pkg::CH_W-2:0], div_ge};
                    r_dsr  <= r_dsr >>> 1;
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'd7) begin
                        r_rgb <= {r_rgb[15:0], r_q[ttr_pkg::CH_W-2:0], div_ge};
                        if (r_ch == 2'd2) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_op    <= OP_C1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_PUSH: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_ox     <= r_pend_x;
                            r_oy     <= r_pend_y;
                            r_orgb   <= r_pend_rgb;
                            r_olast  <= 1'b0;
                        end
                        r_pend_v   <= 1'b1;
                        r_pend_x   <= r_x;
                        r_pend_y   <= r_y;
                        r_pend_rgb <= r_rgb;
                        r_state    <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (at_end) begin
                        r_state <= S_FLUSH;
                    end else begin
                        if (r_x == r_lx1) begin
                            r_x <= r_lx0;
                            r_y <= r_y + 12'd1;
                        end else begin
                            r_x <= r_x + 12'd1;
                        end
                        r_op    <= OP_W1A;
                        r_state <= S_MUL;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_ox     <= r_pend_x;
                        r_oy     <= r_pend_y;
                        r_orgb   <= r_pend_rgb;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_tri.ready        = (r_state == S_IDLE);
    assign o_pix.valid        = r_ovalid;
    assign o_pix.pixel_x      = r_ox;
    assign o_pix.pixel_y      = r_oy;
    assign o_pix.pixel_rgb    = r_orgb;
    assign o_pix.last_of_tile = r_olast;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_tri.valid) |=> (r_state == S_SETUP))
        else $error("accepted triangle did not start setup");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pixel left pending between triangles");

    a_flush_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_load) |=> (r_ovalid && o_pix.last_of_tile))
        else $error("final pixel of a tile not flagged last");

    a_area_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_area > 0))
        else $error("division with non-positive area");

endmodule
